### design/pump_dryrun_runtime_supervisor_defines.svh
// Assertion macros for the pump dry-run supervisor.
// No dependencies; included by the top level only.
`ifndef PUMP_DRYRUN_RUNTIME_SUPERVISOR_DEFINES_SVH
`define PUMP_DRYRUN_RUNTIME_SUPERVISOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define PDRS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define PDRS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/pdrs_pkg.sv
// Shared types and constants of the pump dry-run supervisor.
// No dependencies; imported by pdrs_window, pdrs_ctrl and the top level.
`default_nettype none

package pdrs_pkg;

    // Field widths
    localparam int ADC_W      = 10;
    localparam int CUR_W      = 15;
    localparam int CNT_W      = 8;
    localparam int TIMER_W    = 10;
    localparam int PIDX_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // Empty window entry: inverted reading of zero current
    localparam logic [ADC_W-1:0] ADC_IDLE = 10'h3FF;

    // current = floor((1024 - median) * 10000 / 409), done as (x * CUR_MULT) >> CUR_SHIFT.
    // CUR_MULT = ceil(10000 * 2^20 / 409); exact for x in 1..1024.
    localparam int                 CUR_MULT_W = 25;
    localparam logic [CUR_MULT_W-1:0] CUR_MULT = 25'd25637556;
    localparam int                 CUR_SHIFT  = 20;
    localparam logic [ADC_W:0]     CUR_BASE   = 11'd1024;
    localparam logic [CUR_W-1:0]   CUR_MAX    = 15'd25036;

    // Configuration reset values
    localparam logic [CUR_W-1:0]   ON_TH_RST     = 15'd800;
    localparam logic [CUR_W-1:0]   DRY_TH_RST    = 15'd2000;
    localparam logic [CNT_W-1:0]   DRY_MIN_RST   = 8'd30;
    localparam logic [TIMER_W-1:0] RUN_LIMIT_RST = 10'd900;

    // Button debounce reload
    localparam logic [1:0] REL_LOAD = 2'd2;

    typedef enum logic [2:0] {
        MODE_DRY  = 3'd0,
        MODE_OFF  = 3'd1,
        MODE_IDLE = 3'd2,
        MODE_RUN  = 3'd3,
        MODE_WARN = 3'd4
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ON_TH     = 2'd0,
        CFG_DRY_TH    = 2'd1,
        CFG_DRY_MIN   = 2'd2,
        CFG_RUN_LIMIT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CUR_W-1:0]   on_th;
        logic [CUR_W-1:0]   dry_th;
        logic [CNT_W-1:0]   dry_min;
        logic [TIMER_W-1:0] run_limit;
    } t_cfg;

    typedef struct packed {
        t_mode              mode;
        logic [TIMER_W-1:0] timer;
        logic               relay;
        logic [PIDX_W-1:0]  pidx;
        logic [CNT_W-1:0]   low;
        logic               latch;
        logic [1:0]         rel;
    } t_ctrl_st;

    localparam t_ctrl_st CTRL_RESET = '{
        mode:  MODE_OFF,
        timer: '0,
        relay: 1'b0,
        pidx:  '0,
        low:   '0,
        latch: 1'b0,
        rel:   '0
    };

    typedef struct packed {
        logic             above_on;
        logic [CUR_W-1:0] current_ma;
        t_mode            mode_code;
        logic             relay_on;
    } t_result;

endpackage

`default_nettype wire

### design/pdrs_window.sv
// Median window of inverted ADC samples and conversion of the median to mA.
// Depends on pdrs_pkg.
`default_nettype none

module pdrs_window #(
    parameter int WINDOW = 5
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_sample,
    input  wire logic [pdrs_pkg::ADC_W-1:0] i_adc,
    output logic      [pdrs_pkg::CUR_W-1:0] o_current_ma,
    output logic                            o_full
);
    import pdrs_pkg::*;

    localparam int IW  = $clog2(WINDOW);
    localparam int FW  = $clog2(WINDOW + 1);
    localparam int MID = WINDOW / 2;
    localparam int PW  = ADC_W + 1 + CUR_MULT_W;

    logic [ADC_W-1:0] r_window [WINDOW];
    logic [ADC_W-1:0] n_window [WINDOW];
    logic [IW-1:0]    r_wpos, n_wpos;
    logic [FW-1:0]    r_fill, n_fill;
    logic [IW-1:0]    rank [WINDOW];
    logic [ADC_W-1:0] med;
    logic [ADC_W:0]   x;
    logic [PW-1:0]    prod;

    // Window after this item's sample
    always_comb begin
        for (int k = 0; k < WINDOW; k++) begin
            n_window[k] = (i_sample && (r_wpos == IW'(k))) ? i_adc : r_window[k];
        end
    end

    always_comb begin
        n_wpos = r_wpos;
        n_fill = r_fill;
        if (i_sample) begin
            n_wpos = (r_wpos == IW'(WINDOW - 1)) ? '0 : r_wpos + IW'(1);
            if (r_fill != FW'(WINDOW)) begin
                n_fill = r_fill + FW'(1);
            end
        end
    end

    assign o_full = (n_fill == FW'(WINDOW));

    // Sorted position of each entry; ties broken by slot number
    always_comb begin
        for (int i = 0; i < WINDOW; i++) begin
            rank[i] = '0;
            for (int j = 0; j < WINDOW; j++) begin
                if ((j != i) && ((n_window[j] < n_window[i]) ||
                                 ((n_window[j] == n_window[i]) && (j < i)))) begin
                    rank[i] = rank[i] + IW'(1);
                end
            end
        end
    end

    // Pick the middle entry
    always_comb begin
        med = '0;
        for (int i = 0; i < WINDOW; i++) begin
            if (rank[i] == IW'(MID)) begin
                med = med | n_window[i];
            end
        end
    end

    // Scale to milliamperes
    assign x            = CUR_BASE - {1'b0, med};
    assign prod         = PW'(x) * PW'(CUR_MULT);
    assign o_current_ma = prod[CUR_SHIFT +: CUR_W];

    // Window storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW; k++) begin
                r_window[k] <= ADC_IDLE;
            end
            r_wpos <= '0;
            r_fill <= '0;
        end else if (i_en) begin
            for (int k = 0; k < WINDOW; k++) begin
                r_window[k] <= n_window[k];
            end
            r_wpos <= n_wpos;
            r_fill <= n_fill;
        end
    end

endmodule

`default_nettype wire

### design/pdrs_ctrl.sv
// Button debounce, dry-run detection and the off/idle/run/warning state machine.
// Depends on pdrs_pkg.
`default_nettype none

module pdrs_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_sample,
    input  wire logic                       i_button,
    input  wire logic                       i_second,
    input  wire logic [pdrs_pkg::CUR_W-1:0] i_current_ma,
    input  wire logic                       i_full,
    input  wire pdrs_pkg::t_cfg             i_cfg,
    output pdrs_pkg::t_result               o_res
);
    import pdrs_pkg::*;

    // Warning relay pattern, bit i is step i
    localparam int                 PAT_LEN = 14;
    localparam logic [PAT_LEN-1:0] PATTERN = 14'b11111100111100;

    t_ctrl_st r_st, n_st;
    logic     active;

    // Relay change reloads the run-limit timer
    function automatic t_ctrl_st f_set_relay(t_ctrl_st s, logic on, logic [TIMER_W-1:0] lim);
        t_ctrl_st r;
        r = s;
        if (r.relay != on) begin
            r.timer = lim;
        end
        r.relay = on;
        return r;
    endfunction

    function automatic t_ctrl_st f_enter(t_ctrl_st s, t_mode m, logic [TIMER_W-1:0] lim);
        t_ctrl_st r;
        r      = s;
        r.mode = m;
        unique case (m)
            MODE_IDLE, MODE_RUN: begin
                r = f_set_relay(r, 1'b1, lim);
            end
            MODE_WARN: begin
                r.pidx = '0;
                r      = f_set_relay(r, PATTERN[0], lim);
            end
            default: begin
                r = f_set_relay(r, 1'b0, lim);
            end
        endcase
        return r;
    endfunction

    assign active = (i_current_ma > i_cfg.on_th);

    // Next state: sample first, then the second tick
    always_comb begin
        t_ctrl_st s;
        logic     fire;
        logic     timeout;
        logic     tg;
        s       = r_st;
        fire    = 1'b0;
        timeout = 1'b0;
        tg      = 1'b0;

        if (i_sample) begin
            if (i_button) begin
                if (!s.latch) begin
                    if (s.mode >= MODE_IDLE) begin
                        s = f_enter(s, MODE_OFF, i_cfg.run_limit);
                    end else begin
                        s = f_enter(s, MODE_IDLE, i_cfg.run_limit);
                    end
                end
                s.latch = 1'b1;
                s.rel   = REL_LOAD;
            end else if (s.latch) begin
                if (s.rel != 2'd0) begin
                    s.rel = s.rel - 2'd1;
                end
                if (s.rel == 2'd0) begin
                    s.latch = 1'b0;
                end
            end
        end

        if (i_second) begin
            // dry-run check, any mode
            if (!active) begin
                s.low = '0;
            end else if (i_current_ma < i_cfg.dry_th) begin
                fire = (s.low > i_cfg.dry_min);
                if (s.low != {CNT_W{1'b1}}) begin
                    s.low = s.low + CNT_W'(1);
                end
                if (fire) begin
                    s = f_enter(s, MODE_DRY, i_cfg.run_limit);
                end
            end

            // machine steps only with a full window
            if (i_full) begin
                if (s.timer != '0) begin
                    s.timer = s.timer - TIMER_W'(1);
                end
                timeout = (s.timer == '0);
                unique case (s.mode)
                    MODE_IDLE: begin
                        if (active) begin
                            s = f_enter(s, MODE_RUN, i_cfg.run_limit);
                        end else if (timeout) begin
                            s = f_enter(s, MODE_OFF, i_cfg.run_limit);
                        end
                    end
                    MODE_RUN: begin
                        if (!active) begin
                            s = f_enter(s, MODE_IDLE, i_cfg.run_limit);
                        end else if (timeout) begin
                            s = f_enter(s, MODE_WARN, i_cfg.run_limit);
                        end
                    end
                    MODE_WARN: begin
                        s.pidx = s.pidx + PIDX_W'(1);
                        if (s.pidx >= PIDX_W'(PAT_LEN)) begin
                            s = f_enter(s, MODE_OFF, i_cfg.run_limit);
                        end else begin
                            tg = (s.relay != PATTERN[s.pidx]);
                            s  = f_set_relay(s, PATTERN[s.pidx], i_cfg.run_limit);
                            if (!tg && s.relay && !active) begin
                                s = f_enter(s, MODE_IDLE, i_cfg.run_limit);
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        n_st = s;
    end

    // Result of this item, taken after all updates
    always_comb begin
        o_res.relay_on   = n_st.relay;
        o_res.mode_code  = n_st.mode;
        o_res.current_ma = i_current_ma;
        o_res.above_on   = active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= CTRL_RESET;
        end else if (i_en) begin
            r_st <= n_st;
        end
    end

endmodule

`default_nettype wire

### design/pump_dryrun_runtime_supervisor.sv
// Pump dry-run supervisor, top level. A taken item passes the input register, then the
// result register, and then appears on m_axis. Throughput: one item per cycle while
// m_axis_tready does not stall it; the path per item is the median ranking plus one
// constant multiply. Reset: synchronous, active low; window refilled with 1023,
// mode off, counters and timer zero, thresholds back to defaults. No clearing pass.
`default_nettype none
`include "pump_dryrun_runtime_supervisor_defines.svh"

module pump_dryrun_runtime_supervisor #(
    parameter int WINDOW = 5
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // config write port
    input  wire logic                            i_cfg_we,
    input  wire logic [pdrs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [pdrs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input items
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [15:0]                     s_axis_tdata,  // adc_value[9:0], button_pressed[10]
    input  wire logic [1:0]                      s_axis_tuser,  // sample_tick[0], second_tick[1]
    // result items
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [23:0]                          m_axis_tdata   // relay_on[0], mode_code[3:1],
                                                                // current_ma[18:4], above_on[19]
);
    import pdrs_pkg::*;

    t_cfg             r_cfg;
    logic             r_in_valid;
    logic             r_in_sample;
    logic [ADC_W-1:0] r_in_adc;
    logic             r_in_button;
    logic             r_in_second;
    logic             r_out_valid;
    t_result          r_res;
    t_result          n_res;
    logic             advance;
    logic [CUR_W-1:0] cur_ma;
    logic             win_full;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.on_th     <= ON_TH_RST;
            r_cfg.dry_th    <= DRY_TH_RST;
            r_cfg.dry_min   <= DRY_MIN_RST;
            r_cfg.run_limit <= RUN_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ON_TH:     r_cfg.on_th     <= i_cfg_data[CUR_W-1:0];
                CFG_DRY_TH:    r_cfg.dry_th    <= i_cfg_data[CUR_W-1:0];
                CFG_DRY_MIN:   r_cfg.dry_min   <= i_cfg_data[CNT_W-1:0];
                CFG_RUN_LIMIT: r_cfg.run_limit <= i_cfg_data[TIMER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Handshake: the input register moves into the result register when it is free
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_sample <= s_axis_tuser[0];
            r_in_second <= s_axis_tuser[1];
            r_in_adc    <= s_axis_tdata[ADC_W-1:0];
            r_in_button <= s_axis_tdata[ADC_W];
        end
    end

    pdrs_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (advance),
        .i_sample     (r_in_sample),
        .i_adc        (r_in_adc),
        .o_current_ma (cur_ma),
        .o_full       (win_full)
    );

    pdrs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (advance),
        .i_sample     (r_in_sample),
        .i_button     (r_in_button),
        .i_second     (r_in_second),
        .i_current_ma (cur_ma),
        .i_full       (win_full),
        .i_cfg        (r_cfg),
        .o_res        (n_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_res.above_on, r_res.current_ma,
                            r_res.mode_code, r_res.relay_on};

    // Relay follows the mode: off in dry run and off, on in idle and running
    `PDRS_ASSERT_IMP(a_relay_off_modes, i_clk, i_rst_n, r_out_valid && ((r_res.mode_code == MODE_DRY) || (r_res.mode_code == MODE_OFF)), !r_res.relay_on, "relay on in dry run or off")
    `PDRS_ASSERT_IMP(a_relay_on_modes, i_clk, i_rst_n, r_out_valid && ((r_res.mode_code == MODE_IDLE) || (r_res.mode_code == MODE_RUN)), r_res.relay_on, "relay off in idle or running")
    // Scaled current never exceeds the full-scale value
    `PDRS_ASSERT_IMP(a_current_range, i_clk, i_rst_n, r_out_valid, r_res.current_ma <= CUR_MAX, "current out of range")
    // A held input item is not dropped
    `PDRS_ASSERT_NXT(a_in_held, i_clk, i_rst_n, r_in_valid && !advance, r_in_valid, "input item lost")

endmodule

`default_nettype wire

### tb/pdrs_checker.sv
// Checker for the pump dry-run supervisor: watches the config port and both streams,
// predicts every result item and compares it field by field. Depends on pdrs_pkg.
`timescale 1ns / 100ps

module pdrs_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [pdrs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [pdrs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    input  wire logic                            i_in_ready,
    input  wire logic [15:0]                     i_in_data,   // adc_value[9:0], button_pressed[10]
    input  wire logic [1:0]                      i_in_user,   // sample_tick[0], second_tick[1]
    input  wire logic                            i_out_valid,
    input  wire logic                            i_out_ready,
    input  wire logic [23:0]                     i_out_data,  // relay_on[0], mode_code[3:1],
                                                              // current_ma[18:4], above_on[19]
    output int                                   o_fail_count,
    output int                                   o_pending
);
    import pdrs_pkg::*;

    localparam int WINDOW      = 5;
    localparam int PATTERN_LEN = 14;
    // relay level per warning step, step 0 in bit 0
    localparam logic [PATTERN_LEN-1:0] RELAY_SEQ = 14'b11111100111100;

    typedef struct packed {
        logic             relay;
        t_mode            state;
        logic [CUR_W-1:0] ma;
        logic             active;
    } t_pump_status;

    // shadow copy of the block
    t_cfg               cfg;
    logic [ADC_W-1:0]   win [WINDOW];
    int                 wr_pos;
    logic [2:0]         fill;
    t_mode              mode;
    logic [TIMER_W-1:0] timer;
    logic               relay;
    logic [PIDX_W-1:0]  pidx;
    logic [CNT_W-1:0]   low_cnt;
    logic               btn_latch;
    logic [1:0]         rel_cnt;

    t_pump_status status_due_q[$];
    int           fail_count = 0;

    function automatic void clear_pump_model();
        cfg.on_th     = ON_TH_RST;
        cfg.dry_th    = DRY_TH_RST;
        cfg.dry_min   = DRY_MIN_RST;
        cfg.run_limit = RUN_LIMIT_RST;
        for (int i = 0; i < WINDOW; i++) win[i] = ADC_IDLE;
        wr_pos    = 0;
        fill      = '0;
        mode      = MODE_OFF;
        timer     = '0;
        relay     = 1'b0;
        pidx      = '0;
        low_cnt   = '0;
        btn_latch = 1'b0;
        rel_cnt   = '0;
    endfunction

    // median of the window, then scaled to milliamperes
    function automatic logic [CUR_W-1:0] median_to_ma();
        logic [ADC_W-1:0] s [WINDOW];
        logic [ADC_W-1:0] t;
        int unsigned      x;
        for (int i = 0; i < WINDOW; i++) s[i] = win[i];
        for (int i = 1; i < WINDOW; i++) begin
            for (int j = i; j > 0 && s[j-1] > s[j]; j--) begin
                t      = s[j];
                s[j]   = s[j-1];
                s[j-1] = t;
            end
        end
        x = 1024 - s[WINDOW/2];
        return CUR_W'((x * 10000) / 409);
    endfunction

    // any relay change reloads the run-limit timer
    function automatic void drive_relay(logic on);
        if (relay != on) timer = cfg.run_limit;
        relay = on;
    endfunction

    function automatic void go_mode(t_mode m);
        mode = m;
        case (m)
            MODE_IDLE, MODE_RUN: drive_relay(1'b1);
            MODE_WARN: begin
                pidx = '0;
                drive_relay(RELAY_SEQ[0]);
            end
            default: drive_relay(1'b0);
        endcase
    endfunction

    // once-per-second step of idle / running / warning
    function automatic void machine_second(logic active);
        logic expired;
        logic want;
        logic flipped;
        if (timer != '0) timer--;
        expired = (timer == '0);
        case (mode)
            MODE_IDLE: begin
                if (active) go_mode(MODE_RUN);
                else if (expired) go_mode(MODE_OFF);
            end
            MODE_RUN: begin
                if (!active) go_mode(MODE_IDLE);
                else if (expired) go_mode(MODE_WARN);
            end
            MODE_WARN: begin
                pidx++;
                if (pidx >= PATTERN_LEN) begin
                    go_mode(MODE_OFF);
                end else begin
                    want    = RELAY_SEQ[pidx];
                    flipped = (relay != want);
                    drive_relay(want);
                    if (!flipped && relay && !active) go_mode(MODE_IDLE);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic t_pump_status next_pump_status(logic smp, logic [ADC_W-1:0] adc,
                                                      logic btn, logic sec);
        logic [CUR_W-1:0] ma;
        logic             active;
        logic             fire;
        t_pump_status     st;
        // sample: window push and button debounce
        if (smp) begin
            win[wr_pos] = adc;
            wr_pos      = (wr_pos == WINDOW - 1) ? 0 : wr_pos + 1;
            if (fill < WINDOW) fill++;
            if (btn) begin
                if (!btn_latch) begin
                    if (mode >= MODE_IDLE) go_mode(MODE_OFF);
                    else go_mode(MODE_IDLE);
                end
                btn_latch = 1'b1;
                rel_cnt   = REL_LOAD;
            end else if (btn_latch) begin
                if (rel_cnt != '0) rel_cnt--;
                if (rel_cnt == '0) btn_latch = 1'b0;
            end
        end
        // second: dry-run check in every mode, then the state machine
        if (sec) begin
            ma     = median_to_ma();
            active = ma > cfg.on_th;
            if (!active) begin
                low_cnt = '0;
            end else if (ma < cfg.dry_th) begin
                fire = low_cnt > cfg.dry_min;
                if (low_cnt != 8'hFF) low_cnt++;
                if (fire) go_mode(MODE_DRY);
            end
            if (fill >= WINDOW) machine_second(active);
        end
        ma        = median_to_ma();
        st.relay  = relay;
        st.state  = mode;
        st.ma     = ma;
        st.active = ma > cfg.on_th;
        return st;
    endfunction

    function automatic void check_field(string what, int unsigned want, int unsigned got);
        if (want != got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_pump_status want;
        if (!i_rst_n) begin
            clear_pump_model();
            status_due_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ON_TH:     cfg.on_th     = i_cfg_data[CUR_W-1:0];
                    CFG_DRY_TH:    cfg.dry_th    = i_cfg_data[CUR_W-1:0];
                    CFG_DRY_MIN:   cfg.dry_min   = i_cfg_data[CNT_W-1:0];
                    CFG_RUN_LIMIT: cfg.run_limit = i_cfg_data[TIMER_W-1:0];
                    default: ;
                endcase
            end
            // a result leaves through the input and result registers after its item is taken, so compare before queuing
            if (i_out_valid && i_out_ready) begin
                if (status_due_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: result item with none expected, expected nothing, actual %h",
                             $time, i_out_data);
                end else begin
                    want = status_due_q.pop_front();
                    check_field("relay_on", want.relay, i_out_data[0]);
                    check_field("mode_code", want.state, i_out_data[3:1]);
                    check_field("current_ma", want.ma, i_out_data[18:4]);
                    check_field("above_on", want.active, i_out_data[19]);
                end
            end
            if (i_in_valid && i_in_ready)
                status_due_q.push_back(next_pump_status(i_in_user[0], i_in_data[9:0],
                                                        i_in_data[10], i_in_user[1]));
        end
        o_fail_count = fail_count;
        o_pending    = status_due_q.size();
    end

endmodule

### tb/testbench.sv
// Top of the pump dry-run supervisor testbench: clock, reset, config writes and item
// stimulus with random idling. Depends on pdrs_pkg, the block and pdrs_checker.
`timescale 1ns / 100ps

module testbench;
    import pdrs_pkg::*;

    typedef enum int { BAND_ZERO, BAND_LOW, BAND_HIGH, BAND_ANY } t_adc_band;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata = '0;   // adc_value[9:0], button_pressed[10]
    logic [1:0]            s_axis_tuser = '0;   // sample_tick[0], second_tick[1]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [23:0]           m_axis_tdata;        // relay_on[0], mode_code[3:1],
                                                // current_ma[18:4], above_on[19]
    int fail_count;
    int pending;

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    // long receiver hold-off, requested by the stimulus and counted by the receiver
    int hold_len = 0;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;

    pump_dryrun_runtime_supervisor u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    pdrs_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #2 i_clk = ~i_clk;

    // receiver: random stalls, or a counted hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99, 0) >= rcv_idle_pct);
        end
    end

    initial begin
        #1_600_000;
        $display("simulation failed");
        $finish;
    end

    // offer one item, entered and left at a falling edge
    task automatic put_item(input logic smp, input logic [9:0] adc, input logic btn,
                            input logic sec);
        while (snd_idle_pct > 0 && $urandom_range(99, 0) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 16'($urandom);
            s_axis_tuser  <= 2'($urandom);
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, btn, adc};
        s_axis_tuser  <= {sec, smp};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // sender goes quiet until every result item has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic set_config(input int on_ma, input int dry_ma, input int dry_s,
                              input int lim_s);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_ON_TH;
        i_cfg_data <= CFG_DATA_W'(on_ma);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_DRY_TH;
        i_cfg_data <= CFG_DATA_W'(dry_ma);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_DRY_MIN;
        i_cfg_data <= CFG_DATA_W'(dry_s);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_RUN_LIMIT;
        i_cfg_data <= CFG_DATA_W'(lim_s);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // current bands held for a while so the median settles, with spikes and
    // short button presses mixed in
    task automatic random_run(input int n);
        t_adc_band  band;
        int         band_left;
        int         btn_left;
        logic       smp;
        logic       btn;
        logic       sec;
        logic [9:0] adc;
        band      = BAND_ANY;
        band_left = 0;
        btn_left  = 0;
        for (int k = 0; k < n; k++) begin
            if (band_left == 0) begin
                band      = t_adc_band'($urandom_range(3, 0));
                band_left = $urandom_range(40, 5);
            end
            band_left--;
            smp = ($urandom_range(99, 0) < 75);
            sec = ($urandom_range(99, 0) < 35);
            case (band)
                BAND_ZERO: adc = 10'($urandom_range(1023, 1000));
                BAND_LOW:  adc = 10'($urandom_range(995, 930));
                BAND_HIGH: adc = 10'($urandom_range(930, 0));
                default:   adc = 10'($urandom_range(1023, 0));
            endcase
            if ($urandom_range(99, 0) < 5) adc = 10'($urandom_range(1023, 0));
            btn = 1'($urandom_range(1, 0));
            if (smp) begin
                if (btn_left == 0 && $urandom_range(99, 0) < 6) btn_left = $urandom_range(3, 1);
                btn = (btn_left > 0);
                if (btn_left > 0) btn_left--;
            end
            put_item(smp, adc, btn, sec);
        end
    endtask

    initial begin
        int on_tab  [7] = '{800, 0,     800, 25100, 500,  2000, 800};
        int dry_tab [7] = '{2000, 25100, 2000, 0,   3000, 1000, 2000};
        int min_tab [7] = '{30,  0,     3,   254,   1,    10,   5};
        int lim_tab [7] = '{900, 1,     3,   1023,  5,    2,    4};

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: short run limit so warning and its pattern are reached quickly
        snd_idle_pct = 34;
        rcv_idle_pct = 81;
        set_config(800, 2000, 0, 2);
        put_item(1'b0, 10'd1023, 1'b0, 1'b0);   // no tick at all
        put_item(1'b0, 10'd0, 1'b1, 1'b1);      // second tick on an empty window
        put_item(1'b1, 10'd0, 1'b1, 1'b0);      // press: off to idle
        put_item(1'b1, 10'd0, 1'b0, 1'b0);
        put_item(1'b1, 10'd0, 1'b0, 1'b0);      // released after two samples
        put_item(1'b1, 10'd0, 1'b0, 1'b1);      // window one short: no step
        put_item(1'b1, 10'd0, 1'b0, 1'b1);      // window full: idle to running
        put_item(1'b0, 10'd0, 1'b0, 1'b1);      // timeout: running to warning
        repeat (14) put_item(1'b0, 10'd0, 1'b0, 1'b1);  // walk the pattern out to off
        put_item(1'b1, 10'd1023, 1'b1, 1'b1);   // press and second in one item

        // back-pressure: receiver holds off while the sender keeps offering
        drain();
        hold_len = 80;
        hold_seq++;
        random_run(30);

        for (int ph = 0; ph < 8; ph++) begin
            drain();
            if (ph < 7)
                set_config(on_tab[ph], dry_tab[ph], min_tab[ph], lim_tab[ph]);
            else
                set_config($urandom_range(25100, 0), $urandom_range(25100, 0),
                           $urandom_range(254, 0), $urandom_range(12, 1));
            snd_idle_pct = (ph < 3) ? 34 : (ph < 6) ? 81 : 0;
            rcv_idle_pct = (ph < 3) ? 81 : (ph < 6) ? 34 : 0;
            random_run(160);
        end

        drain();
        repeat (4) @(negedge i_clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### files.f
+incdir+design
design/pdrs_pkg.sv
design/pdrs_window.sv
design/pdrs_ctrl.sv
design/pump_dryrun_runtime_supervisor.sv
tb/pdrs_checker.sv
tb/testbench.sv
